>>> hw/rtl/smfp_pkg.sv
// Shared types and constants for the MIDI file track event parser.
package smfp_pkg;

    typedef enum logic [3:0] {
        PH_FILE_HDR  = 4'd0,
        PH_TRACK_HDR = 4'd1,
        PH_DELTA     = 4'd2,
        PH_STATUS    = 4'd3,
        PH_DATA1     = 4'd4,
        PH_DATA2     = 4'd5,
        PH_META_TYPE = 4'd6,
        PH_META_LEN  = 4'd7,
        PH_SYSEX_LEN = 4'd8,
        PH_SKIP      = 4'd9,
        PH_DONE      = 4'd10
    } smfp_phase_t;

    typedef enum logic [0:0] {
        CT_RUN = 1'b0,
        CT_DIV = 1'b1
    } smfp_ctrl_state_t;

    typedef enum logic [2:0] {
        K_NOTE_OFF = 3'd0,
        K_NOTE_ON  = 3'd1,
        K_CHANNEL  = 3'd2,
        K_TEMPO    = 3'd3,
        K_END      = 3'd4,
        K_UNKNOWN  = 3'd5
    } smfp_kind_t;

    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_PROG      = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRES = 8'hD0;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_EOT     = 8'h2F;

    localparam int          FILE_HDR_LEN  = 14;
    localparam int          TRACK_HDR_LEN = 8;
    localparam int          QUOT_W        = 26;
    localparam int          TEMPO_W       = 24;
    localparam logic [25:0] US_PER_MIN    = 26'd60000000;

    typedef struct packed {
        logic step;      // input beat taken this cycle
        logic div_load;  // quotient ready, load into result register
    } smfp_cmd_t;

    typedef struct packed {
        logic tempo_req; // current input beat needs a division
        logic div_done;
        logic out_busy;  // result register full
    } smfp_stat_t;

endpackage

>>> hw/rtl/smfp_div.sv
// Serial restoring divider: 60000000 / tempo, one quotient bit per cycle.
module smfp_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [smfp_pkg::TEMPO_W-1:0]    divisor,
    output logic                            done,
    output logic [smfp_pkg::QUOT_W-1:0]     quotient
);
    logic                          busy_reg, busy_next;
    logic [4:0]                    cnt_reg, cnt_next;
    logic [smfp_pkg::TEMPO_W-1:0]  rem_reg, rem_next;
    logic [smfp_pkg::TEMPO_W-1:0]  dvs_reg, dvs_next;
    logic [smfp_pkg::QUOT_W-1:0]   dvd_reg, dvd_next;
    logic [smfp_pkg::QUOT_W-1:0]   quo_reg, quo_next;
    logic [smfp_pkg::TEMPO_W:0]    trial;
    logic [smfp_pkg::TEMPO_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[smfp_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        done      = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'(smfp_pkg::QUOT_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            dvd_next  = smfp_pkg::US_PER_MIN;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[smfp_pkg::QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[smfp_pkg::TEMPO_W-1:0];
                quo_next = {quo_reg[smfp_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                rem_next = trial[smfp_pkg::TEMPO_W-1:0];
                quo_next = {quo_reg[smfp_pkg::QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = quo_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end
endmodule

>>> hw/rtl/smfp_ctrl.sv
// Controller: input handshake and sequencing of the tempo division.
module smfp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   m_tready,
    input  smfp_pkg::smfp_stat_t   stat,
    output smfp_pkg::smfp_cmd_t    cmd
);
    smfp_pkg::smfp_ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smfp_pkg::CT_RUN: begin
                if (cmd.step && stat.tempo_req) state_next = smfp_pkg::CT_DIV;
            end
            smfp_pkg::CT_DIV: begin
                if (stat.div_done) state_next = smfp_pkg::CT_RUN;
            end
            default: state_next = smfp_pkg::CT_RUN;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.div_load = 1'b0;
        case (state_reg)
            smfp_pkg::CT_RUN: s_tready = !stat.out_busy || m_tready;
            smfp_pkg::CT_DIV: cmd.div_load = stat.div_done;
            default: s_tready = 1'b0;
        endcase
        cmd.step = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smfp_pkg::CT_RUN;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> hw/rtl/smfp_dp.sv
// Datapath: byte parser registers, event decode and result register.
module smfp_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  smfp_pkg::smfp_cmd_t            cmd,
    input  logic [7:0]                     data_byte,
    input  logic                           file_start,
    input  logic                           m_tready,
    input  logic [smfp_pkg::QUOT_W-1:0]    quotient,
    output logic                           tempo_req,
    output logic                           out_busy,
    output logic [smfp_pkg::TEMPO_W-1:0]   tempo_div,
    output logic                           out_valid,
    output logic [2:0]                     out_kind,
    output logic [15:0]                    out_track,
    output logic [7:0]                     out_key,
    output logic [7:0]                     out_vel,
    output logic [31:0]                    out_delta,
    output logic [23:0]                    out_tempo,
    output logic [25:0]                    out_bpm
);
    smfp_pkg::smfp_phase_t ph_reg, ph_next, c_ph;
    logic [3:0]  hc_reg, hc_next, c_hc;
    logic [15:0] tt_reg, tt_next, c_tt;
    logic [15:0] ct_reg, ct_next, c_ct;
    logic [7:0]  rs_reg, rs_next, c_rs;
    logic [7:0]  as_reg, as_next, c_as;
    logic [31:0] da_reg, da_next, c_da;
    logic [7:0]  fd_reg, fd_next, c_fd;
    logic [7:0]  mt_reg, mt_next, c_mt;
    logic [31:0] pr_reg, pr_next, c_pr;
    logic [23:0] tv_reg, tv_next, c_tv;
    logic [1:0]  tb_reg, tb_next, c_tb;

    logic        emit;
    smfp_pkg::smfp_kind_t e_kind;
    logic [7:0]  e_key, e_vel;
    logic [23:0] e_tempo;

    logic        vld_reg;
    logic [2:0]  kind_reg;
    logic [15:0] trk_reg;
    logic [7:0]  key_reg, vel_reg;
    logic [31:0] dl_reg;
    logic [23:0] tmp_reg;
    logic [25:0] bpm_reg;

    always_comb begin
        logic [31:0] len;
        logic [15:0] nt;
        logic [31:0] prm;
        logic [7:0]  a;
        // a new file restarts the parse before this byte is taken
        c_ph = file_start ? smfp_pkg::PH_FILE_HDR : ph_reg;
        c_hc = file_start ? '0 : hc_reg;
        c_tt = file_start ? '0 : tt_reg;
        c_ct = file_start ? '0 : ct_reg;
        c_rs = file_start ? '0 : rs_reg;
        c_as = file_start ? '0 : as_reg;
        c_da = file_start ? '0 : da_reg;
        c_fd = file_start ? '0 : fd_reg;
        c_mt = file_start ? '0 : mt_reg;
        c_pr = file_start ? '0 : pr_reg;
        c_tv = file_start ? '0 : tv_reg;
        c_tb = file_start ? '0 : tb_reg;
        ph_next = c_ph; hc_next = c_hc; tt_next = c_tt; ct_next = c_ct;
        rs_next = c_rs; as_next = c_as; da_next = c_da; fd_next = c_fd;
        mt_next = c_mt; pr_next = c_pr; tv_next = c_tv; tb_next = c_tb;
        emit    = 1'b0;
        e_kind  = smfp_pkg::K_UNKNOWN;
        e_key   = '0;
        e_vel   = '0;
        e_tempo = '0;
        len     = {c_pr[24:0], data_byte[6:0]};
        nt      = c_ct + 16'd1;
        prm     = c_pr - 32'd1;
        a       = c_rs;
        case (c_ph)
            smfp_pkg::PH_FILE_HDR: begin
                if (c_hc == 4'd10 || c_hc == 4'd11) tt_next = {c_tt[7:0], data_byte};
                hc_next = c_hc + 4'd1;
                if (hc_next == 4'(smfp_pkg::FILE_HDR_LEN)) begin
                    hc_next = '0;
                    ct_next = '0;
                    ph_next = (tt_next == '0) ? smfp_pkg::PH_DONE
                                              : smfp_pkg::PH_TRACK_HDR;
                end
            end
            smfp_pkg::PH_TRACK_HDR: begin
                hc_next = c_hc + 4'd1;
                if (hc_next == 4'(smfp_pkg::TRACK_HDR_LEN)) begin
                    hc_next = '0;
                    rs_next = '0;
                    ph_next = smfp_pkg::PH_DELTA;
                    da_next = '0;
                end
            end
            smfp_pkg::PH_DELTA: begin
                da_next = {c_da[24:0], data_byte[6:0]};
                if (!data_byte[7]) ph_next = smfp_pkg::PH_STATUS;
            end
            smfp_pkg::PH_STATUS: begin
                if (!data_byte[7]) begin
                    if (c_rs[7] && c_rs[7:4] != smfp_pkg::ST_SYSEX[7:4]) begin
                        as_next = c_rs;
                        fd_next = data_byte;
                        if (a[7:4] == smfp_pkg::ST_PROG[7:4] ||
                            a[7:4] == smfp_pkg::ST_CHAN_PRES[7:4]) begin
                            emit    = 1'b1;
                            e_kind  = smfp_pkg::K_CHANNEL;
                            e_key   = data_byte;
                            ph_next = smfp_pkg::PH_DELTA;
                            da_next = '0;
                        end else begin
                            ph_next = smfp_pkg::PH_DATA2;
                        end
                    end else begin
                        // orphan data byte doubles as the next delta
                        emit    = 1'b1;
                        da_next = {24'd0, data_byte};
                    end
                end else if (data_byte[7:4] != smfp_pkg::ST_SYSEX[7:4]) begin
                    rs_next = data_byte;
                    as_next = data_byte;
                    ph_next = smfp_pkg::PH_DATA1;
                end else begin
                    rs_next = '0;
                    if (data_byte == smfp_pkg::ST_META) begin
                        ph_next = smfp_pkg::PH_META_TYPE;
                    end else if (data_byte == smfp_pkg::ST_SYSEX ||
                                 data_byte == smfp_pkg::ST_SYSEX_END) begin
                        mt_next = '0;
                        pr_next = '0;
                        ph_next = smfp_pkg::PH_SYSEX_LEN;
                    end else begin
                        emit    = 1'b1;
                        ph_next = smfp_pkg::PH_DELTA;
                        da_next = '0;
                    end
                end
            end
            smfp_pkg::PH_DATA1: begin
                fd_next = data_byte;
                if (c_as[7:4] == smfp_pkg::ST_PROG[7:4] ||
                    c_as[7:4] == smfp_pkg::ST_CHAN_PRES[7:4]) begin
                    emit    = 1'b1;
                    e_kind  = smfp_pkg::K_CHANNEL;
                    e_key   = data_byte;
                    ph_next = smfp_pkg::PH_DELTA;
                    da_next = '0;
                end else begin
                    ph_next = smfp_pkg::PH_DATA2;
                end
            end
            smfp_pkg::PH_DATA2: begin
                emit  = 1'b1;
                e_key = c_fd;
                e_vel = data_byte;
                if (c_as[7:4] == smfp_pkg::ST_NOTE_OFF[7:4]) begin
                    e_kind = smfp_pkg::K_NOTE_OFF;
                end else if (c_as[7:4] == smfp_pkg::ST_NOTE_ON[7:4]) begin
                    e_kind = (data_byte == '0) ? smfp_pkg::K_NOTE_OFF
                                               : smfp_pkg::K_NOTE_ON;
                end else begin
                    e_kind = smfp_pkg::K_CHANNEL;
                end
                ph_next = smfp_pkg::PH_DELTA;
                da_next = '0;
            end
            smfp_pkg::PH_META_TYPE: begin
                mt_next = data_byte;
                pr_next = '0;
                ph_next = smfp_pkg::PH_META_LEN;
            end
            smfp_pkg::PH_META_LEN: begin
                pr_next = len;
                if (!data_byte[7]) begin
                    tb_next = '0;
                    if (c_mt == smfp_pkg::META_TEMPO && c_tv == '0 && len >= 32'd3)
                        tb_next = 2'd3;
                    if (c_mt == smfp_pkg::META_EOT) begin
                        emit   = 1'b1;
                        e_kind = smfp_pkg::K_END;
                        if (len == '0) begin
                            ct_next = nt;
                            hc_next = '0;
                            ph_next = (nt >= c_tt) ? smfp_pkg::PH_DONE
                                                   : smfp_pkg::PH_TRACK_HDR;
                        end else begin
                            ph_next = smfp_pkg::PH_SKIP;
                        end
                    end else if (len == '0) begin
                        ph_next = smfp_pkg::PH_DELTA;
                        da_next = '0;
                    end else begin
                        ph_next = smfp_pkg::PH_SKIP;
                    end
                end
            end
            smfp_pkg::PH_SYSEX_LEN: begin
                pr_next = len;
                if (!data_byte[7]) begin
                    if (len == '0) begin
                        ph_next = smfp_pkg::PH_DELTA;
                        da_next = '0;
                    end else begin
                        ph_next = smfp_pkg::PH_SKIP;
                    end
                end
            end
            smfp_pkg::PH_SKIP: begin
                if (c_tb != '0) begin
                    tv_next = {c_tv[15:0], data_byte};
                    tb_next = c_tb - 2'd1;
                    if (c_tb == 2'd1) begin
                        emit    = 1'b1;
                        e_kind  = smfp_pkg::K_TEMPO;
                        e_tempo = tv_next;
                    end
                end
                pr_next = prm;
                if (prm == '0) begin
                    if (c_mt == smfp_pkg::META_EOT) begin
                        ct_next = nt;
                        hc_next = '0;
                        ph_next = (nt >= c_tt) ? smfp_pkg::PH_DONE
                                               : smfp_pkg::PH_TRACK_HDR;
                    end else begin
                        ph_next = smfp_pkg::PH_DELTA;
                        da_next = '0;
                    end
                end
            end
            default: ph_next = c_ph;
        endcase
    end

    assign tempo_req = emit && e_kind == smfp_pkg::K_TEMPO && e_tempo != '0;
    assign tempo_div = e_tempo;
    assign out_busy  = vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= smfp_pkg::PH_FILE_HDR;
            hc_reg  <= '0; tt_reg <= '0; ct_reg <= '0; rs_reg <= '0;
            as_reg  <= '0; da_reg <= '0; fd_reg <= '0; mt_reg <= '0;
            pr_reg  <= '0; tv_reg <= '0; tb_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            if (cmd.step) begin
                ph_reg <= ph_next; hc_reg <= hc_next; tt_reg <= tt_next;
                ct_reg <= ct_next; rs_reg <= rs_next; as_reg <= as_next;
                da_reg <= da_next; fd_reg <= fd_next; mt_reg <= mt_next;
                pr_reg <= pr_next; tv_reg <= tv_next; tb_reg <= tb_next;
            end
            if (cmd.div_load || (cmd.step && emit && !tempo_req)) begin
                vld_reg <= 1'b1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
        if (cmd.step && emit) begin
            kind_reg <= e_kind;
            trk_reg  <= c_ct;
            key_reg  <= e_key;
            vel_reg  <= e_vel;
            dl_reg   <= c_da;
            tmp_reg  <= e_tempo;
            bpm_reg  <= '0;
        end
        if (cmd.div_load) bpm_reg <= quotient;
    end

    assign out_valid = vld_reg;
    assign out_kind  = kind_reg;
    assign out_track = trk_reg;
    assign out_key   = key_reg;
    assign out_vel   = vel_reg;
    assign out_delta = dl_reg;
    assign out_tempo = tmp_reg;
    assign out_bpm   = bpm_reg;
endmodule

>>> hw/rtl/smf_track_event_parser.sv
// Top level of the MIDI file track event parser.
// Takes one file byte per beat and returns at most one event beat per byte.
// The input stalls only in two cases. The byte that completes the first
// nonzero tempo starts a serial divider (one quotient bit per cycle),
// and the input stalls until beats per minute is known. A held result
// blocks the next byte until the result beat is taken.
module smf_track_event_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] file_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] track_index, [23:16] note_key, [31:24] note_velocity,
    // [63:32] delta_ticks, [87:64] tempo_us, [113:88] beats_per_minute, pad
    output logic [119:0] m_tdata,
    output logic [2:0]   m_tuser    // [2:0] kind
);
    smfp_pkg::smfp_cmd_t  cmd;
    smfp_pkg::smfp_stat_t stat;
    logic [smfp_pkg::QUOT_W-1:0]  quotient;
    logic [smfp_pkg::TEMPO_W-1:0] tempo_div;
    logic        tempo_req, out_busy, div_done;
    logic [15:0] trk;
    logic [7:0]  key, vel;
    logic [31:0] dl;
    logic [23:0] tmp;
    logic [25:0] bpm;

    assign stat = '{tempo_req: tempo_req, div_done: div_done, out_busy: out_busy};

    smfp_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tready, .stat, .cmd
    );

    smfp_dp u_dp (
        .aclk, .aresetn, .cmd,
        .data_byte (s_tdata),
        .file_start(s_tuser[0]),
        .m_tready,
        .quotient,
        .tempo_req (tempo_req),
        .out_busy  (out_busy),
        .tempo_div,
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_track (trk),
        .out_key   (key),
        .out_vel   (vel),
        .out_delta (dl),
        .out_tempo (tmp),
        .out_bpm   (bpm)
    );

    smfp_div u_div (
        .aclk, .aresetn,
        .start   (cmd.step && tempo_req),
        .divisor (tempo_div),
        .done    (div_done),
        .quotient
    );

    assign m_tdata = {6'd0, bpm, tmp, dl, vel, key, trk};
endmodule

>>> hw/rtl/smfp_checker.sv
// Port-level checks for the MIDI file track event parser, bound to the top.
module smfp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [2:0]   m_tuser
);
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= smfp_pkg::K_UNKNOWN)
        else $error("kind out of range");

    a_tempo_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != smfp_pkg::K_TEMPO) |-> m_tdata[113:64] == '0)
        else $error("tempo fields set on non-tempo beat");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped while stalled");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind smf_track_event_parser smfp_checker u_smfp_checker (.*);
